// File: design/tksk_pkg.sv
// tksk_pkg: shared types and codes for the top-k score keeper.
// Used by tksk_cell, top_k_score_keeper and tksk_checker; depends on nothing.
package tksk_pkg;

    localparam int SCORE_W = 16;
    localparam int TAG_W   = 16;
    localparam int LIMIT_W = 7;
    localparam int HELD_W  = 7;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_DRAIN  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_DRAIN = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic                 evict;
        logic [SCORE_W-1:0]   score;
        logic [TAG_W-1:0]     tag;
    } cell_ctrl_t;

endpackage

// File: design/tksk_cell.sv
// tksk_cell: one slot of the sorted chain, holding a score and its tag.
// Depends on tksk_pkg; exchanges data and compare flags with both neighbors.
module tksk_cell
    import tksk_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic               head,
    input  logic               occupied,
    input  logic               prev_le,
    input  logic [SCORE_W-1:0] prev_score,
    input  logic [TAG_W-1:0]   prev_tag,
    input  logic               next_le,
    input  logic [SCORE_W-1:0] next_score,
    input  logic [TAG_W-1:0]   next_tag,
    output logic               le,
    output logic [SCORE_W-1:0] score,
    output logic [TAG_W-1:0]   tag
);

    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;

    // occupied slot whose score does not exceed the incoming one
    assign le    = occupied && (score_reg <= ctrl.score);
    assign score = score_reg;
    assign tag   = tag_reg;

    always_comb
    begin
        score_next = score_reg;
        tag_next   = tag_reg;
        unique case (ctrl.op)
            OP_SHIFT:
            begin
                score_next = next_score;
                tag_next   = next_tag;
            end
            OP_INSERT:
            begin
                if (ctrl.evict)
                begin
                    // lowest entry leaves: the chain closes up toward the head
                    if (next_le)
                    begin
                        score_next = next_score;
                        tag_next   = next_tag;
                    end
                    else if (head || le)
                    begin
                        score_next = ctrl.score;
                        tag_next   = ctrl.tag;
                    end
                end
                else
                begin
                    if (!le)
                    begin
                        if (head || prev_le)
                        begin
                            score_next = ctrl.score;
                            tag_next   = ctrl.tag;
                        end
                        else
                        begin
                            score_next = prev_score;
                            tag_next   = prev_tag;
                        end
                    end
                end
            end
            default:
            begin
                score_next = score_reg;
                tag_next   = tag_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

endmodule

// File: design/top_k_score_keeper.sv
// top_k_score_keeper: bounded store of (score, tag) entries kept in ascending order.
// Depends on tksk_pkg and tksk_cell (one cell per slot in a shifting chain).
//
// Usage:
//   Command channel: a word (mode, score, entry_tag) is taken at a rising edge
//   with start high and busy low. Insert and clear return nothing; a new
//   command may follow in the next cycle.
//   Query returns one word in the cycle after it is taken, and does not raise busy.
//   Drain of n held entries raises busy; the chain shifts one slot
//   toward the head each cycle, so entries leave lowest first, one word per
//   cycle, once busy and then the output registers have taken the command. Drain of an empty store
//   returns one empty marker in the cycle after it is taken, without raising busy.
//   Results: strobe marks each word for exactly one cycle; the receiver cannot
//   stall the block, so it must take every word as it comes.
//   Configuration: cfg_we with cfg_data writes keep_limit (0 or above DEPTH means
//   DEPTH); write only while idle.
//   Reset: rst_n clears the held count, the limit and the output strobe; the
//   slot contents are not cleared and are never read before being written.
module top_k_score_keeper
    import tksk_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [SCORE_W-1:0] score,
    input  logic [TAG_W-1:0]   entry_tag,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data,
    output logic               strobe,
    output logic [1:0]         kind,
    output logic               admitted,
    output logic [SCORE_W-1:0] out_score,
    output logic [TAG_W-1:0]   out_tag,
    output logic [HELD_W-1:0]  held_now,
    output logic               last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [LIMIT_W-1:0] keep_limit_reg;
    logic [CW-1:0]      held_count_reg;
    logic [CW-1:0]      held_count_next;
    logic               draining_reg;
    logic [CW-1:0]      left_reg;
    logic [CW-1:0]      left_next;
    logic [HELD_W-1:0]  drain_held_reg;

    logic               strobe_reg;
    logic               strobe_next;
    logic [1:0]         kind_reg;
    logic [1:0]         kind_next;
    logic               admitted_reg;
    logic               admitted_next;
    logic [SCORE_W-1:0] out_score_reg;
    logic [SCORE_W-1:0] out_score_next;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [TAG_W-1:0]   out_tag_next;
    logic [HELD_W-1:0]  held_now_reg;
    logic [HELD_W-1:0]  held_now_next;
    logic               last_reg;
    logic               last_next;

    logic               accept;
    logic [CW-1:0]      limit_eff;
    logic               at_limit;
    cell_ctrl_t         ctrl;

    logic               le_w    [DEPTH];
    logic [SCORE_W-1:0] score_w [DEPTH];
    logic [TAG_W-1:0]   tag_w   [DEPTH];

    assign accept = start && !draining_reg;
    assign busy   = draining_reg;

    assign limit_eff = ((keep_limit_reg == '0) || (keep_limit_reg > LIMIT_W'(DEPTH)))
                       ? CW'(DEPTH) : keep_limit_reg[CW-1:0];
    // limit is at least one, so a full store is never empty
    assign at_limit  = (held_count_reg >= limit_eff);

    always_comb
    begin
        ctrl.score = score;
        ctrl.tag   = entry_tag;
        ctrl.evict = at_limit;
        if (draining_reg)
        begin
            ctrl.op = OP_SHIFT;
        end
        else if (accept && (mode == MODE_INSERT))
        begin
            ctrl.op = OP_INSERT;
        end
        else
        begin
            ctrl.op = OP_HOLD;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic               prev_le_c;
        logic [SCORE_W-1:0] prev_score_c;
        logic [TAG_W-1:0]   prev_tag_c;
        logic               next_le_c;
        logic [SCORE_W-1:0] next_score_c;
        logic [TAG_W-1:0]   next_tag_c;

        if (i == 0)
        begin : g_head
            assign prev_le_c    = 1'b0;
            assign prev_score_c = '0;
            assign prev_tag_c   = '0;
        end
        else
        begin : g_body
            assign prev_le_c    = le_w[i-1];
            assign prev_score_c = score_w[i-1];
            assign prev_tag_c   = tag_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_le_c    = 1'b0;
            assign next_score_c = '0;
            assign next_tag_c   = '0;
        end
        else
        begin : g_inner
            assign next_le_c    = le_w[i+1];
            assign next_score_c = score_w[i+1];
            assign next_tag_c   = tag_w[i+1];
        end

        tksk_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .head       ((i == 0) ? 1'b1 : 1'b0),
            .occupied   (CW'(i) < held_count_reg),
            .prev_le    (prev_le_c),
            .prev_score (prev_score_c),
            .prev_tag   (prev_tag_c),
            .next_le    (next_le_c),
            .next_score (next_score_c),
            .next_tag   (next_tag_c),
            .le         (le_w[i]),
            .score      (score_w[i]),
            .tag        (tag_w[i])
        );
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        left_next       = left_reg;
        strobe_next     = 1'b0;
        kind_next       = KIND_QUERY;
        admitted_next   = 1'b0;
        out_score_next  = '0;
        out_tag_next    = '0;
        held_now_next   = HELD_W'(held_count_reg);
        last_next       = 1'b0;

        if (draining_reg)
        begin
            // emit the head slot while the chain shifts toward it
            strobe_next    = 1'b1;
            kind_next      = KIND_DRAIN;
            out_score_next = score_w[0];
            out_tag_next   = tag_w[0];
            held_now_next  = drain_held_reg;
            last_next      = (left_reg == CW'(1));
            left_next      = left_reg - CW'(1);
        end
        else if (accept)
        begin
            unique case (mode)
                MODE_INSERT:
                begin
                    if (!at_limit)
                    begin
                        held_count_next = held_count_reg + CW'(1);
                    end
                end
                MODE_QUERY:
                begin
                    strobe_next   = 1'b1;
                    kind_next     = KIND_QUERY;
                    admitted_next = !at_limit || (score > score_w[0]);
                    last_next     = 1'b1;
                end
                MODE_DRAIN:
                begin
                    held_count_next = '0;
                    left_next       = held_count_reg;
                    if (held_count_reg == '0)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_EMPTY;
                        last_next   = 1'b1;
                    end
                end
                MODE_CLEAR:
                begin
                    held_count_next = '0;
                end
                default:
                begin
                    held_count_next = held_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_limit_reg <= '0;
            held_count_reg <= '0;
            draining_reg   <= 1'b0;
            left_reg       <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                keep_limit_reg <= cfg_data;
            end
            held_count_reg <= held_count_next;
            left_reg       <= left_next;
            strobe_reg     <= strobe_next;
            if (draining_reg)
            begin
                draining_reg <= (left_reg != CW'(1));
            end
            else if (accept && (mode == MODE_DRAIN) && (held_count_reg != '0))
            begin
                draining_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        admitted_reg  <= admitted_next;
        out_score_reg <= out_score_next;
        out_tag_reg   <= out_tag_next;
        held_now_reg  <= held_now_next;
        last_reg      <= last_next;
        if (!draining_reg)
        begin
            drain_held_reg <= HELD_W'(held_count_reg);
        end
    end

    assign strobe    = strobe_reg;
    assign kind      = kind_reg;
    assign admitted  = admitted_reg;
    assign out_score = out_score_reg;
    assign out_tag   = out_tag_reg;
    assign held_now  = held_now_reg;
    assign last      = last_reg;

endmodule

// File: design/tksk_checker.sv
// tksk_checker: port-level assertions for top_k_score_keeper, bound to the top.
// Depends on tksk_pkg for the result kind codes.
module tksk_checker
    import tksk_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               strobe,
    input logic [1:0]         kind,
    input logic [SCORE_W-1:0] out_score,
    input logic [TAG_W-1:0]   out_tag,
    input logic [HELD_W-1:0]  held_now,
    input logic               last
);

    // a drain keeps streaming one word per cycle until its final word
    a_drain_stream: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_DRAIN) && !last |=> strobe && (kind == KIND_DRAIN))
        else $error("drain stream broke before its final word");

    // busy drops exactly when the final drained word shows
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && (kind == KIND_DRAIN) && last)
        else $error("busy fell without a final drained word");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_EMPTY) |-> last && (held_now == '0) && !busy)
        else $error("empty marker malformed");

    a_query_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_QUERY) |-> last && (out_score == '0) && (out_tag == '0))
        else $error("query answer malformed");

endmodule

bind top_k_score_keeper tksk_checker u_tksk_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .strobe    (strobe),
    .kind      (kind),
    .out_score (out_score),
    .out_tag   (out_tag),
    .held_now  (held_now),
    .last      (last)
);

// File: test/top_k_score_keeper_test.sv
// top_k_score_keeper_test: self-checking bench for the bounded top-k score store.
// Depends on tksk_pkg and top_k_score_keeper; a directed table, then random phases,
// each word checked against a sorted mirror of the store kept in the bench.
`timescale 1ns / 100ps

module top_k_score_keeper_test;
    import tksk_pkg::*;

    localparam int DEPTH         = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int FINISH_LIMIT  = 400;
    localparam int PHASES        = 8;
    localparam int RANDOM_LIMIT  = -1;

    typedef struct packed {
        logic [1:0]         kind;
        logic               admitted;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic [HELD_W-1:0]  held;
        logic               last;
    } word_t;

    typedef enum logic {
        ROW_COMMAND,
        ROW_LIMIT
    } row_kind_t;

    typedef struct packed {
        row_kind_t          row_kind;
        logic [LIMIT_W-1:0] limit_value;
        logic [1:0]         mode;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic               typed;
        word_t              want;
    } stim_row_t;

    localparam word_t NO_WORD        = '0;
    localparam word_t EMPTY_MARK     = '{KIND_EMPTY, 1'b0, 16'h0, 16'h0, 7'd0, 1'b1};
    localparam word_t ADMIT_ON_EMPTY = '{KIND_QUERY, 1'b1, 16'h0, 16'h0, 7'd0, 1'b1};

    localparam stim_row_t DIRECTED_ROWS [31] = '{
        '{ROW_COMMAND, 7'd0,   MODE_DRAIN,  16'h0000, 16'h0000, 1'b1, EMPTY_MARK},
        '{ROW_COMMAND, 7'd0,   MODE_QUERY,  16'h0000, 16'h0000, 1'b1, ADMIT_ON_EMPTY},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'hFFFF, 16'hFFFF, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h0000, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h8000, 16'h1234, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h8000, 16'h5678, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_CLEAR,  16'h0000, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_QUERY,  16'hFFFF, 16'hFFFF, 1'b1, ADMIT_ON_EMPTY},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h8000, 16'hAAAA, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h8000, 16'h5555, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h0001, 16'h0001, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'hFFFE, 16'hFFFE, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_DRAIN,  16'h0000, 16'h0000, 1'b0, NO_WORD},
        '{ROW_LIMIT,   7'd2,   MODE_INSERT, 16'h0000, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h0100, 16'h0001, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h0100, 16'h0002, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_QUERY,  16'h0100, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_QUERY,  16'h0101, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h0100, 16'h0003, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_DRAIN,  16'h0000, 16'h0000, 1'b0, NO_WORD},
        '{ROW_LIMIT,   7'd0,   MODE_INSERT, 16'h0000, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h3000, 16'h0030, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h1000, 16'h0010, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h2000, 16'h0020, 1'b0, NO_WORD},
        '{ROW_LIMIT,   7'd1,   MODE_INSERT, 16'h0000, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_INSERT, 16'h0500, 16'h0005, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_QUERY,  16'h0500, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_DRAIN,  16'h0000, 16'h0000, 1'b0, NO_WORD},
        '{ROW_LIMIT,   7'd127, MODE_INSERT, 16'h0000, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_QUERY,  16'h7FFF, 16'h0000, 1'b0, NO_WORD},
        '{ROW_COMMAND, 7'd0,   MODE_DRAIN,  16'h0000, 16'h0000, 1'b1, EMPTY_MARK}
    };

    // Per phase: limit, commands, insert share, query share (percent), idle chance.
    localparam int PHASE_LIMIT [PHASES] = '{3, 0, 1, 9, 127, 64, RANDOM_LIMIT, 5};
    localparam int PHASE_ITEMS [PHASES] = '{30, 45, 25, 30, 25, 20, 30, 25};
    localparam int PHASE_INS   [PHASES] = '{55, 85, 50, 55, 60, 60, 55, 55};
    localparam int PHASE_QRY   [PHASES] = '{30, 15, 30, 25, 20, 25, 25, 25};
    localparam int PHASE_IDLE  [PHASES] = '{30, 10, 40, 0, 25, 20, 30, 0};

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic [1:0]         mode      = MODE_INSERT;
    logic [SCORE_W-1:0] score     = '0;
    logic [TAG_W-1:0]   entry_tag = '0;
    logic               cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] cfg_data  = '0;
    logic               busy;
    logic               strobe;
    logic [1:0]         kind;
    logic               admitted;
    logic [SCORE_W-1:0] out_score;
    logic [TAG_W-1:0]   out_tag;
    logic [HELD_W-1:0]  held_now;
    logic               last;

    // Mirror of the store, lowest score at index zero.
    logic [SCORE_W-1:0] ladder_score [DEPTH];
    logic [TAG_W-1:0]   ladder_tag   [DEPTH];
    int                 ladder_count = 0;
    logic [LIMIT_W-1:0] limit_reg    = '0;

    word_t awaited_words [$];
    int    failures = 0;

    top_k_score_keeper #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .score     (score),
        .entry_tag (entry_tag),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .kind      (kind),
        .admitted  (admitted),
        .out_score (out_score),
        .out_tag   (out_tag),
        .held_now  (held_now),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("top_k_score_keeper verification failed");
        $finish;
    end

    // Update the mirror for one taken command and queue the words it yields.
    function automatic void apply_command(logic [1:0] m, logic [SCORE_W-1:0] s,
                                          logic [TAG_W-1:0] t);
        int    lim;
        int    pos;
        int    i;
        word_t w;
        lim = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
        w = NO_WORD;
        case (m)
            MODE_INSERT:
            begin
                // a full store drops its lowest entry whatever the new score
                if (ladder_count >= lim && ladder_count > 0)
                begin
                    for (i = 0; i < ladder_count - 1; i++)
                    begin
                        ladder_score[i] = ladder_score[i + 1];
                        ladder_tag[i]   = ladder_tag[i + 1];
                    end
                    ladder_count--;
                end
                pos = 0;
                while (pos < ladder_count && ladder_score[pos] <= s)
                    pos++;
                for (i = ladder_count; i > pos; i--)
                begin
                    ladder_score[i] = ladder_score[i - 1];
                    ladder_tag[i]   = ladder_tag[i - 1];
                end
                ladder_score[pos] = s;
                ladder_tag[pos]   = t;
                ladder_count++;
            end
            MODE_QUERY:
            begin
                w.kind = KIND_QUERY;
                w.held = HELD_W'(ladder_count);
                w.last = 1'b1;
                if (ladder_count < lim)
                    w.admitted = 1'b1;
                else
                    w.admitted = (ladder_count > 0) && (s > ladder_score[0]);
                awaited_words.push_back(w);
            end
            MODE_DRAIN:
            begin
                if (ladder_count == 0)
                begin
                    w.kind = KIND_EMPTY;
                    w.last = 1'b1;
                    awaited_words.push_back(w);
                end
                for (i = 0; i < ladder_count; i++)
                begin
                    w.kind  = KIND_DRAIN;
                    w.score = ladder_score[i];
                    w.tag   = ladder_tag[i];
                    w.held  = HELD_W'(ladder_count);
                    w.last  = (i == ladder_count - 1);
                    awaited_words.push_back(w);
                end
                ladder_count = 0;
            end
            default:
                ladder_count = 0;
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : word_check
        word_t want;
        if (strobe === 1'b1)
        begin
            if (awaited_words.size() == 0)
            begin
                failures++;
                $display("%0t: word expected none got kind %0h score %0h tag %0h",
                         $time, kind, out_score, out_tag);
            end
            else
            begin
                want = awaited_words.pop_front();
                check_field("kind", 16'(want.kind), 16'(kind));
                check_field("admitted", 16'(want.admitted), 16'(admitted));
                check_field("out_score", want.score, out_score);
                check_field("out_tag", want.tag, out_tag);
                check_field("held_now", 16'(want.held), 16'(held_now));
                check_field("last", 16'(want.last), 16'(last));
            end
        end
    end

    // Present one word and hold it until the block takes it; start stays high.
    task automatic issue_word(logic [1:0] m, logic [SCORE_W-1:0] s, logic [TAG_W-1:0] t);
        start     <= 1'b1;
        mode      <= m;
        score     <= s;
        entry_tag <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_command(m, s, t);
    endtask

    task automatic pause_sender(int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
    endtask

    // Drain everything in flight, let the chain settle, then write the limit.
    task automatic write_limit(logic [LIMIT_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (awaited_words.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_reg = v;
    endtask

    task automatic random_command(int ins_w, int qry_w);
        logic [1:0]         m;
        logic [SCORE_W-1:0] s;
        int                 r;
        r = $urandom_range(99);
        if (r < ins_w)
            m = MODE_INSERT;
        else if (r < ins_w + qry_w)
            m = MODE_QUERY;
        else if ($urandom_range(1) == 1)
            m = MODE_DRAIN;
        else
            m = MODE_CLEAR;
        case ($urandom_range(9))
            0, 1, 2: s = 16'($urandom_range(7)) << 13;
            3:       s = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
            // land on or next to the lowest kept score to probe the strict compare
            4:       s = (ladder_count > 0) ? ladder_score[0] + 16'($urandom_range(2)) - 16'd1
                                            : 16'h0000;
            default: s = 16'($urandom);
        endcase
        issue_word(m, s, 16'($urandom));
    endtask

    initial
    begin : stimulus
        stim_row_t row;
        int        ph;
        int        k;
        int        n;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < $size(DIRECTED_ROWS); k++)
        begin
            row = DIRECTED_ROWS[k];
            if (row.row_kind == ROW_LIMIT)
                write_limit(row.limit_value);
            else
            begin
                issue_word(row.mode, row.score, row.tag);
                // the typed word stands in for the predicted one
                if (row.typed)
                begin
                    void'(awaited_words.pop_back());
                    awaited_words.push_back(row.want);
                end
                pause_sender(30);
            end
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (PHASE_LIMIT[ph] == RANDOM_LIMIT)
                write_limit(LIMIT_W'($urandom_range(127)));
            else
                write_limit(LIMIT_W'(PHASE_LIMIT[ph]));
            for (k = 0; k < PHASE_ITEMS[ph]; k++)
            begin
                random_command(PHASE_INS[ph], PHASE_QRY[ph]);
                pause_sender(PHASE_IDLE[ph]);
            end
            // odd phases other than the last carry their entries into the next limit
            if (ph % 2 == 0 || ph == PHASES - 1)
                issue_word(MODE_DRAIN, 16'($urandom), 16'($urandom));
        end

        start <= 1'b0;
        for (n = 0; n < FINISH_LIMIT && awaited_words.size() != 0; n++)
            @(posedge clk);
        if (awaited_words.size() != 0)
        begin
            failures++;
            $display("%0t: %0d words never arrived", $time, awaited_words.size());
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
        if (failures == 0)
            $display("top_k_score_keeper verification clean");
        else
            $display("top_k_score_keeper verification failed");
        $finish;
    end

endmodule
